// ===== rtl/xsr_pkg.sv =====
`default_nettype none

package xsr_pkg;

    // splitmix64 constants
    localparam logic [63:0] SM_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] SM_MUL1   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] SM_MUL2   = 64'h94d0_49bb_1331_11eb;

    // xoshiro256++ shift and rotate amounts
    localparam int unsigned XS_ROT_OUT = 23;
    localparam int unsigned XS_SHIFT   = 17;
    localparam int unsigned XS_ROT_ST  = 45;

    // splitmix64 xor-shift amounts
    localparam int unsigned SM_SH_A = 30;
    localparam int unsigned SM_SH_B = 27;
    localparam int unsigned SM_SH_C = 31;

    // number of state words and the index width
    localparam int unsigned STATE_WORDS = 4;
    localparam int unsigned WORD_IDX_W  = $clog2(STATE_WORDS);

    // input action codes
    localparam logic ACT_RESEED = 1'b0;
    localparam logic ACT_NEXT   = 1'b1;

    // partial product steps of the shared 32x32 multiplier
    localparam logic [1:0] MP_LO_LO = 2'd0;
    localparam logic [1:0] MP_LO_HI = 2'd1;
    localparam logic [1:0] MP_HI_LO = 2'd2;
    localparam logic [1:0] MP_LAST  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_ADD,
        ST_SEED_MUL1,
        ST_SEED_MUL2
    } state_t;

    // rotate a 64-bit word left by a constant amount
    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
        return (v << n) | (v >> (64 - n));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/xoshiro256pp_generator.sv =====
`default_nettype none

// xoshiro256++ pseudo-random generator with splitmix64 seeding.
// Input channel (in_valid/in_ready): action selects reseed or next word;
// seed is used only by reseed items. Output channel (out_valid/out_ready)
// carries random_value, one item per next item and none per reseed item.
// A next item is worked out in the cycle it is accepted and its result
// appears in the output register in the next cycle; next items can be taken
// every cycle, one word per cycle, as long as the receiver keeps taking.
// A reseed item runs four splitmix64 steps on one shared 32x32 multiplier:
// each step is an add state plus two 64-bit products of three partial
// products each, so the input is not ready from the time a reseed item is
// accepted until all four state words have been written.
// When the receiver stalls, the result stays in the output register and no
// new item is taken until it leaves; an item waiting there does not hold up
// the acceptance of the next item in the same cycle it is taken.
// Reset clears the state to all zeros: next items before the first reseed
// give zero words. Reset also empties the output register.
module xoshiro256pp_generator
    import xsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [63:0] seed,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      random_value
);

    state_t                  state_reg, state_next;
    logic [63:0]             s_reg    [STATE_WORDS];
    logic [63:0]             s_next   [STATE_WORDS];
    logic [63:0]             acc_reg, acc_next;
    logic [63:0]             z_reg, z_next;
    logic [63:0]             sum_reg, sum_next;
    logic [63:0]             prod_reg, prod_next;
    logic [1:0]              mul_idx_reg, mul_idx_next;
    logic [WORD_IDX_W-1:0]   word_idx_reg, word_idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [63:0]             rand_reg, rand_next;

    logic                    out_free;
    logic                    in_acc;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [63:0]             mul_const;
    logic [63:0]             sum_add;
    logic [63:0]             add_x;
    logic [63:0]             nx_word;
    logic [63:0]             nx_sh;
    logic [63:0]             nx_t2;
    logic [63:0]             nx_t3;

    // handshake
    assign out_free     = !out_valid_reg || out_ready;
    assign in_ready     = (state_reg == ST_IDLE) && out_free;
    assign in_acc       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign random_value = rand_reg;

    // xoshiro256++ output and advance
    assign nx_word = rotl64(s_reg[0] + s_reg[3], XS_ROT_OUT) + s_reg[0];
    assign nx_sh   = s_reg[1] << XS_SHIFT;
    assign nx_t2   = s_reg[2] ^ s_reg[0];
    assign nx_t3   = s_reg[3] ^ s_reg[1];

    // shared multiplier operands: constant half and state half by step
    assign mul_const = (state_reg == ST_SEED_MUL2) ? SM_MUL2 : SM_MUL1;
    always_comb
    begin
        case (mul_idx_reg)
            MP_LO_LO:
            begin
                mul_a = z_reg[31:0];
                mul_b = mul_const[31:0];
            end
            MP_LO_HI:
            begin
                mul_a = z_reg[31:0];
                mul_b = mul_const[63:32];
            end
            default:
            begin
                mul_a = z_reg[63:32];
                mul_b = mul_const[31:0];
            end
        endcase
    end

    // cross products land in the upper half only
    assign sum_add = sum_reg + {prod_reg[31:0], 32'd0};
    assign add_x   = acc_reg + SM_GOLDEN;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (action == ACT_RESEED))
                begin
                    state_next = ST_SEED_ADD;
                end
            end
            ST_SEED_ADD:
            begin
                state_next = ST_SEED_MUL1;
            end
            ST_SEED_MUL1:
            begin
                if (mul_idx_reg == MP_LAST)
                begin
                    state_next = ST_SEED_MUL2;
                end
            end
            ST_SEED_MUL2:
            begin
                if (mul_idx_reg == MP_LAST)
                begin
                    if (word_idx_reg == WORD_IDX_W'(STATE_WORDS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SEED_ADD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        for (int i = 0; i < STATE_WORDS; i++)
        begin
            s_next[i] = s_reg[i];
        end
        acc_next       = acc_reg;
        z_next         = z_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        mul_idx_next   = mul_idx_reg;
        word_idx_next  = word_idx_reg;
        rand_next      = rand_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                mul_idx_next = MP_LO_LO;
                if (in_acc)
                begin
                    if (action == ACT_NEXT)
                    begin
                        rand_next      = nx_word;
                        out_valid_next = 1'b1;
                        s_next[0]      = s_reg[0] ^ nx_t3;
                        s_next[1]      = s_reg[1] ^ nx_t2;
                        s_next[2]      = nx_t2 ^ nx_sh;
                        s_next[3]      = rotl64(nx_t3, XS_ROT_ST);
                    end
                    else
                    begin
                        acc_next      = seed;
                        word_idx_next = '0;
                    end
                end
            end
            ST_SEED_ADD:
            begin
                acc_next     = add_x;
                z_next       = add_x ^ (add_x >> SM_SH_A);
                mul_idx_next = MP_LO_LO;
            end
            ST_SEED_MUL1, ST_SEED_MUL2:
            begin
                prod_next    = 64'(mul_a) * 64'(mul_b);
                mul_idx_next = mul_idx_reg + 2'd1;
                case (mul_idx_reg)
                    MP_LO_LO:
                    begin
                        sum_next = '0;
                    end
                    MP_LO_HI:
                    begin
                        sum_next = prod_reg;
                    end
                    MP_HI_LO:
                    begin
                        sum_next = sum_add;
                    end
                    default:
                    begin
                        // last cross product added, finish the mix round
                        if (state_reg == ST_SEED_MUL1)
                        begin
                            z_next = sum_add ^ (sum_add >> SM_SH_B);
                        end
                        else
                        begin
                            s_next[word_idx_reg] = sum_add ^ (sum_add >> SM_SH_C);
                            word_idx_next        = word_idx_reg + WORD_IDX_W'(1);
                        end
                    end
                endcase
            end
            default:
            begin
                mul_idx_next = MP_LO_LO;
            end
        endcase
    end

    // control registers and state words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_idx_reg   <= MP_LO_LO;
            word_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STATE_WORDS; i++)
            begin
                s_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mul_idx_reg   <= mul_idx_next;
            word_idx_reg  <= word_idx_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < STATE_WORDS; i++)
            begin
                s_reg[i] <= s_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        z_reg    <= z_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        rand_reg <= rand_next;
    end

`ifndef SYNTH
    // a reseed starts the sequencer at the first state word
    a_reseed_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (action == ACT_RESEED))
        |=> (state_reg == ST_SEED_ADD) && (word_idx_reg == '0))
        else $error("reseed did not start at word zero");

    // a next item always leaves a result in the output register
    a_next_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (action == ACT_NEXT)) |=> out_valid_reg)
        else $error("next item left no result");

    // a reseed never produces a result of its own
    a_seed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEED_ADD) |-> !$rose(out_valid_reg))
        else $error("result appeared during reseed");

    // the multiplier step count is at its start outside the product phases
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEED_ADD) |=> (mul_idx_reg == MP_LO_LO))
        else $error("multiplier step out of line");

    // the fourth word finishes the reseed
    a_seed_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SEED_MUL2) && (mul_idx_reg == MP_LAST)
         && (word_idx_reg == WORD_IDX_W'(STATE_WORDS - 1)))
        |=> (state_reg == ST_IDLE))
        else $error("reseed did not end after the last word");
`endif

endmodule

`default_nettype wire

// ===== tb/xoshiro256pp_generator_tb.sv =====
module xoshiro256pp_generator_tb;
    import xsr_pkg::*;

    localparam int unsigned CLK_HALF     = 6;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned DRAIN_CYCLES = 48;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned MAX_WAIT     = 10;

    typedef enum int unsigned {
        CHK_OK,
        CHK_MISMATCH,
        CHK_UNEXPECTED
    } check_status_t;

    // predicted state of the generator and the words still owed by the block
    class rng_scoreboard_t;
        logic [63:0] gen_word [STATE_WORDS];
        logic [63:0] owed_words [$];

        function new();
            for (int k = 0; k < STATE_WORDS; k++)
                gen_word[k] = '0;
        endfunction

        function logic [63:0] rot_left(logic [63:0] v, int unsigned n);
            return (v << n) | (v >> (64 - n));
        endfunction

        // one splitmix64 step, advancing the running sum
        function logic [63:0] splitmix(inout logic [63:0] acc);
            logic [63:0] z;
            acc = acc + SM_GOLDEN;
            z = acc;
            z = (z ^ (z >> SM_SH_A)) * SM_MUL1;
            z = (z ^ (z >> SM_SH_B)) * SM_MUL2;
            return z ^ (z >> SM_SH_C);
        endfunction

        function void note_input(logic act, logic [63:0] sd);
            logic [63:0] acc;
            logic [63:0] word;
            logic [63:0] sh;
            if (act == ACT_RESEED)
            begin
                acc = sd;
                for (int k = 0; k < STATE_WORDS; k++)
                    gen_word[k] = splitmix(acc);
            end
            else
            begin
                word = rot_left(gen_word[0] + gen_word[3], XS_ROT_OUT) + gen_word[0];
                sh = gen_word[1] << XS_SHIFT;
                gen_word[2] = gen_word[2] ^ gen_word[0];
                gen_word[3] = gen_word[3] ^ gen_word[1];
                gen_word[1] = gen_word[1] ^ gen_word[2];
                gen_word[0] = gen_word[0] ^ gen_word[3];
                gen_word[2] = gen_word[2] ^ sh;
                gen_word[3] = rot_left(gen_word[3], XS_ROT_ST);
                owed_words.insert(owed_words.size(), word);
            end
        endfunction

        function check_status_t check_result(logic [63:0] got, output logic [63:0] want);
            want = '0;
            if (owed_words.size() == 0)
                return CHK_UNEXPECTED;
            want = owed_words.pop_front();
            return (got === want) ? CHK_OK : CHK_MISMATCH;
        endfunction

        function int pending();
            return owed_words.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [63:0] seed;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] random_value;

    rng_scoreboard_t sb;
    int unsigned     mismatch_count;
    int unsigned     cycle_count;
    bit              calm_phase;

    xoshiro256pp_generator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .seed         (seed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .random_value (random_value)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned draw_wait();
        return calm_phase ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // present one item after a random gap and hold it until accepted
    task automatic send_item(input logic act, input logic [63:0] sd);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0)
        begin
            in_valid = 1'b0;
            action   = 1'($urandom_range(0, 1));
            seed     = rand_word();
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        action   = act;
        seed     = sd;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // next items before the first reseed, seed extremes, back-to-back reseeds
    task automatic run_directed();
        send_item(ACT_NEXT, 64'h0);
        send_item(ACT_NEXT, '1);
        send_item(ACT_NEXT, rand_word());
        send_item(ACT_RESEED, 64'h0);
        send_item(ACT_NEXT, 64'h0);
        send_item(ACT_NEXT, '1);
        send_item(ACT_NEXT, 64'h0);
        send_item(ACT_RESEED, '1);
        send_item(ACT_NEXT, rand_word());
        send_item(ACT_NEXT, rand_word());
        send_item(ACT_RESEED, 64'h8000_0000_0000_0000);
        send_item(ACT_RESEED, 64'h0000_0000_0000_0001);
        send_item(ACT_NEXT, '1);
        send_item(ACT_NEXT, 64'h0);
        send_item(ACT_RESEED, 64'h5555_5555_5555_5555);
        send_item(ACT_NEXT, 64'haaaa_aaaa_aaaa_aaaa);
        send_item(ACT_NEXT, 64'h5555_5555_5555_5555);
        send_item(ACT_RESEED, 64'haaaa_aaaa_aaaa_aaaa);
        send_item(ACT_NEXT, rand_word());
        send_item(ACT_NEXT, rand_word());
    endtask

    // mostly next words, with occasional reseeds
    task automatic run_random();
        int unsigned pick;
        logic [63:0] sd;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                calm_phase = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                case ($urandom_range(0, 9))
                    0:       sd = 64'h0;
                    1:       sd = '1;
                    default: sd = rand_word();
                endcase
                send_item(ACT_RESEED, sd);
            end
            else
                send_item(ACT_NEXT, rand_word());
        end
        in_valid = 1'b0;
    endtask

    // stimulus and end of run
    initial
    begin
        sb             = new();
        mismatch_count = 0;
        calm_phase     = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_RESEED;
        seed           = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        run_directed();
        run_random();
        calm_phase = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d words never arrived", sb.pending()));
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stall before each item
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall != 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // accepted input items feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(action, seed);
    end

    // accepted results are checked against the oldest owed word
    always @(posedge clk)
    begin
        logic [63:0]   want;
        check_status_t status;
        if (rst_n && out_valid && out_ready)
        begin
            status = sb.check_result(random_value, want);
            if (status == CHK_UNEXPECTED)
                report_mismatch($sformatf("unexpected word %h", random_value));
            else if (status == CHK_MISMATCH)
                report_mismatch($sformatf("random_value %h, expected %h",
                                          random_value, want));
        end
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule

// ===== filelist.f =====
rtl/xsr_pkg.sv
rtl/xoshiro256pp_generator.sv
tb/xoshiro256pp_generator_tb.sv
